// ===== src/hcb_pkg.sv =====
package hcb_pkg;

    localparam int SYMBOLS   = 256;
    localparam int SYM_W     = 8;
    localparam int CNT_W     = 31;
    localparam int LEN_W     = 6;
    localparam int CODE_W    = 48;
    localparam int MAX_LEN   = 48;
    localparam int IDX_W     = 9;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_BUILD = 2'd1,
        K_ENC   = 2'd2,
        K_FLUSH = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        BS_OK    = 2'd0,
        BS_EMPTY = 2'd1,
        BS_OVF   = 2'd2
    } t_bstat;

    typedef struct packed {
        logic [CNT_W-1:0] w;
        logic [SYM_W-1:0] g;
    } t_node;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLR, OP_LRD, OP_LCHK, OP_IRD, OP_ICMP, OP_LEND,
        OP_ORD, OP_OWR, OP_MRDA, OP_MRDB, OP_MSUM, OP_SRD, OP_SCHK,
        OP_HEAD2, OP_JRD, OP_JCMP, OP_MNEXT, OP_ERR, OP_EMIT,
        OP_ERD, OP_ELD, OP_ESTEP, OP_FOUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        t_bstat st;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic cnt_nz;
        logic k_zero;
        logic node_ge;
        logic s_last;
        logic n_zero;
        logic n_one;
        logic n_gt1;
        logic ovf;
        logic len_err;
        logic k_lt_tail;
        logic node_lt;
        logic rem_zero;
        logic fill_zero;
    } t_dp_stat;

endpackage

// ===== src/hcb_ctrl.sv =====
module hcb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  hcb_pkg::t_kind    i_kind,
    input  hcb_pkg::t_dp_stat i_stat,
    output hcb_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);
    import hcb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_LRD, S_LCHK, S_IRD, S_ICMP, S_LEND, S_ORD, S_OWR,
        S_MRDA, S_MRDB, S_MSUM, S_SRD, S_SCHK, S_HEAD2, S_JRD, S_JCMP,
        S_MNEXT, S_ERR, S_EMIT, S_ERD, S_ELD, S_ESTEP, S_FOUT
    } t_state;

    t_state r_state;
    t_bstat r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= BS_OK;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        case (i_kind)
                            K_BUILD: r_state <= S_CLR;
                            K_ENC:   r_state <= S_ERD;
                            K_FLUSH: r_state <= S_FOUT;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLR:  r_state <= S_LRD;
                S_LRD:  r_state <= S_LCHK;
                S_LCHK: begin
                    if (i_stat.cnt_nz)       r_state <= S_IRD;
                    else if (i_stat.s_last)  r_state <= S_LEND;
                    else                     r_state <= S_LRD;
                end
                S_IRD: begin
                    if (!i_stat.k_zero)      r_state <= S_ICMP;
                    else if (i_stat.s_last)  r_state <= S_LEND;
                    else                     r_state <= S_LRD;
                end
                S_ICMP: begin
                    if (i_stat.node_ge)      r_state <= S_IRD;
                    else if (i_stat.s_last)  r_state <= S_LEND;
                    else                     r_state <= S_LRD;
                end
                S_LEND: begin
                    if (i_stat.n_zero) begin
                        r_st    <= BS_EMPTY;
                        r_state <= S_EMIT;
                    end else if (i_stat.n_one) begin
                        r_state <= S_ORD;
                    end else begin
                        r_state <= S_MRDA;
                    end
                end
                S_ORD: r_state <= S_OWR;
                S_OWR: begin
                    r_st    <= BS_OK;
                    r_state <= S_EMIT;
                end
                S_MRDA: r_state <= S_MRDB;
                S_MRDB: r_state <= S_MSUM;
                S_MSUM: r_state <= i_stat.ovf ? S_ERR : S_SRD;
                S_SRD:  r_state <= S_SCHK;
                S_SCHK: begin
                    if (i_stat.len_err)      r_state <= S_ERR;
                    else if (i_stat.s_last)  r_state <= S_HEAD2;
                    else                     r_state <= S_SRD;
                end
                S_HEAD2: r_state <= S_JRD;
                S_JRD:   r_state <= i_stat.k_lt_tail ? S_JCMP : S_MNEXT;
                S_JCMP:  r_state <= i_stat.node_lt ? S_JRD : S_MNEXT;
                S_MNEXT: begin
                    if (i_stat.n_gt1) begin
                        r_state <= S_MRDA;
                    end else begin
                        r_st    <= BS_OK;
                        r_state <= S_EMIT;
                    end
                end
                S_ERR: begin
                    r_st    <= BS_OVF;
                    r_state <= S_EMIT;
                end
                S_EMIT:  if (i_stat.out_free) r_state <= S_IDLE;
                S_ERD:   r_state <= S_ELD;
                S_ELD:   r_state <= S_ESTEP;
                S_ESTEP: if (i_stat.rem_zero) r_state <= S_IDLE;
                S_FOUT:  if (i_stat.fill_zero) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.st = r_st;
        case (r_state)
            S_CLR:   o_cmd.op = OP_CLR;
            S_LRD:   o_cmd.op = OP_LRD;
            S_LCHK:  o_cmd.op = OP_LCHK;
            S_IRD:   o_cmd.op = OP_IRD;
            S_ICMP:  o_cmd.op = OP_ICMP;
            S_LEND:  o_cmd.op = OP_LEND;
            S_ORD:   o_cmd.op = OP_ORD;
            S_OWR:   o_cmd.op = OP_OWR;
            S_MRDA:  o_cmd.op = OP_MRDA;
            S_MRDB:  o_cmd.op = OP_MRDB;
            S_MSUM:  o_cmd.op = OP_MSUM;
            S_SRD:   o_cmd.op = OP_SRD;
            S_SCHK:  o_cmd.op = OP_SCHK;
            S_HEAD2: o_cmd.op = OP_HEAD2;
            S_JRD:   o_cmd.op = OP_JRD;
            S_JCMP:  o_cmd.op = OP_JCMP;
            S_MNEXT: o_cmd.op = OP_MNEXT;
            S_ERR:   o_cmd.op = OP_ERR;
            S_EMIT:  o_cmd.op = OP_EMIT;
            S_ERD:   o_cmd.op = OP_ERD;
            S_ELD:   o_cmd.op = OP_ELD;
            S_ESTEP: o_cmd.op = OP_ESTEP;
            S_FOUT:  o_cmd.op = OP_FOUT;
            default: o_cmd.op = OP_NOP;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/hcb_dpath.sv =====
module hcb_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hcb_pkg::t_dp_cmd            i_cmd,
    output hcb_pkg::t_dp_stat           o_stat,
    input  logic                        i_accept,
    input  hcb_pkg::t_kind              i_kind,
    input  logic [hcb_pkg::SYM_W-1:0]   i_symbol,
    input  logic [hcb_pkg::CNT_W-1:0]   i_count,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [7:0]                  o_out_byte,
    output logic                        o_is_status,
    output logic [1:0]                  o_status,
    output logic                        o_last
);
    import hcb_pkg::*;

    // storage
    logic [CNT_W-1:0]  m_count [SYMBOLS];
    logic [SYM_W-1:0]  m_group [SYMBOLS];
    logic [LEN_W-1:0]  m_len   [SYMBOLS];
    logic [CODE_W-1:0] m_bits  [SYMBOLS];
    t_node             m_node  [SYMBOLS];
    logic [SYMBOLS-1:0] r_cnt_vld;
    logic [SYMBOLS-1:0] r_len_vld;

    logic [CNT_W-1:0]  r_cnt_rd;
    logic [SYM_W-1:0]  r_grp_rd;
    logic [LEN_W-1:0]  r_len_rd;
    logic [CODE_W-1:0] r_bits_rd;
    t_node             r_node_rd;

    logic [SYM_W-1:0]  r_sym;
    logic [SYM_W-1:0]  r_s;
    logic [IDX_W-1:0]  r_head, r_tail, r_k;
    logic [CNT_W-1:0]  r_w;
    t_node             r_a;
    logic [SYM_W-1:0]  r_bg;
    logic [CNT_W-1:0]  r_sum;

    logic [7:0]        r_buf;
    logic [2:0]        r_fill;
    logic [LEN_W-1:0]  r_rem;
    logic [CODE_W-1:0] r_code;

    logic              r_ov, r_ois, r_olast;
    logic [7:0]        r_ob;
    logic [1:0]        r_ost;

    // combinational helpers
    logic              out_free;
    logic [IDX_W-1:0]  n_live, km1;
    logic [CNT_W:0]    sum_full;
    logic              hit, is_b, len_err;
    logic [SYM_W-1:0]  rd_s, len_wa;
    logic [IDX_W-1:0]  nd_ra, nd_wa;
    logic              nd_we, sym_we;
    t_node             nd_wd;
    logic [LEN_W-1:0]  len_wd;
    logic [CODE_W-1:0] bits_wd;
    logic [3:0]        room, take, new_fill;
    logic              fills;
    logic [7:0]        nb;
    logic [6:0]        bidx;
    logic [LEN_W-1:0]  rem_after;
    logic              step_go, emit_byte;

    assign out_free = !r_ov || !i_out_stall;
    assign n_live   = r_tail - r_head;
    assign km1      = r_k - IDX_W'(1);
    assign sum_full = {1'b0, r_a.w} + {1'b0, r_node_rd.w};
    assign is_b     = (r_grp_rd == r_bg);
    assign hit      = (r_cnt_rd != '0) && ((r_grp_rd == r_a.g) || is_b);
    assign len_err  = hit && (r_len_rd >= LEN_W'(MAX_LEN));

    // encoder chunk: as many code bits as fit into the current byte
    always_comb begin
        room     = 4'd8 - {1'b0, r_fill};
        take     = ({2'b00, r_rem} < {2'b00, room}) ? r_rem[3:0] : room;
        new_fill = {1'b0, r_fill} + take;
        fills    = new_fill[3];
        nb       = r_buf;
        bidx     = '0;
        for (int p = 0; p < 8; p++) begin
            bidx = 7'(r_rem) - 7'd1 - 7'(p) + 7'(r_fill);
            if ((4'(p) >= {1'b0, r_fill}) && (4'(p) < new_fill))
                nb[p] = r_code[bidx[5:0]];
        end
        rem_after = r_rem - LEN_W'(take);
        step_go   = (i_cmd.op == OP_ESTEP) && (r_rem != '0) && (!fills || out_free);
        emit_byte = (step_go && fills) ||
                    ((i_cmd.op == OP_FOUT) && (r_fill != '0) && out_free);
    end

    // memory addressing
    always_comb begin
        rd_s   = (i_cmd.op == OP_ERD) ? r_sym : r_s;
        nd_ra  = r_k;
        nd_we  = 1'b0;
        nd_wa  = r_k;
        nd_wd  = r_node_rd;
        sym_we = 1'b0;
        len_wa = r_s;
        len_wd = r_len_rd + LEN_W'(1);
        bits_wd = ((r_len_rd == '0) ? '0 : r_bits_rd) |
                  (is_b ? (CODE_W'(1) << r_len_rd) : '0);
        case (i_cmd.op)
            OP_IRD: begin
                nd_ra = km1;
                if (r_k == '0) begin
                    nd_we = 1'b1;
                    nd_wd = '{w: r_w, g: r_s};
                end
            end
            OP_ICMP: begin
                nd_we = 1'b1;
                if (r_node_rd.w < r_w) nd_wd = '{w: r_w, g: r_s};
            end
            OP_ORD:  nd_ra = r_head;
            OP_OWR: begin
                sym_we  = 1'b1;
                len_wa  = r_node_rd.g;
                len_wd  = LEN_W'(1);
                bits_wd = CODE_W'(1);
            end
            OP_MRDA: nd_ra = r_head;
            OP_MRDB: nd_ra = r_head + IDX_W'(1);
            OP_SCHK: sym_we = hit && !len_err;
            OP_JRD: begin
                if (r_k >= r_tail) begin
                    nd_we = 1'b1;
                    nd_wa = km1;
                    nd_wd = '{w: r_sum, g: r_a.g};
                end
            end
            OP_JCMP: begin
                nd_we = 1'b1;
                nd_wa = km1;
                if (r_node_rd.w >= r_sum) nd_wd = '{w: r_sum, g: r_a.g};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_kind == K_LOAD)) m_count[i_symbol] <= i_count;
        if ((i_cmd.op == OP_LCHK) && (r_cnt_rd != '0)) m_group[r_s] <= r_s;
        if ((i_cmd.op == OP_SCHK) && hit && !len_err)
            m_group[r_s] <= is_b ? r_a.g : r_grp_rd;
        if (sym_we) begin
            m_len[len_wa]  <= len_wd;
            m_bits[len_wa] <= bits_wd;
        end
        if (nd_we) m_node[nd_wa[SYM_W-1:0]] <= nd_wd;
        r_cnt_rd  <= r_cnt_vld[rd_s] ? m_count[rd_s] : '0;
        r_len_rd  <= r_len_vld[rd_s] ? m_len[rd_s] : '0;
        r_grp_rd  <= m_group[rd_s];
        r_bits_rd <= m_bits[rd_s];
        r_node_rd <= m_node[nd_ra[SYM_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_len_vld <= '0;
            r_buf     <= '0;
            r_fill    <= '0;
            r_rem     <= '0;
            r_ov      <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_k       <= '0;
            r_s       <= '0;
        end else begin
            if (i_accept && (i_kind == K_LOAD)) r_cnt_vld[i_symbol] <= 1'b1;
            if ((i_cmd.op == OP_CLR) || (i_cmd.op == OP_ERR)) r_len_vld <= '0;
            else if (sym_we) r_len_vld[len_wa] <= 1'b1;

            if (i_accept) r_sym <= i_symbol;

            case (i_cmd.op)
                OP_CLR: begin
                    r_head <= '0;
                    r_tail <= '0;
                    r_s    <= '0;
                end
                OP_LCHK: begin
                    if (r_cnt_rd != '0) begin
                        r_w <= r_cnt_rd;
                        r_k <= r_tail;
                    end else begin
                        r_s <= r_s + SYM_W'(1);
                    end
                end
                OP_IRD: begin
                    if (r_k == '0) begin
                        r_tail <= r_tail + IDX_W'(1);
                        r_s    <= r_s + SYM_W'(1);
                    end
                end
                OP_ICMP: begin
                    if (r_node_rd.w >= r_w) begin
                        r_k <= km1;
                    end else begin
                        r_tail <= r_tail + IDX_W'(1);
                        r_s    <= r_s + SYM_W'(1);
                    end
                end
                OP_MRDB: r_a <= r_node_rd;
                OP_MSUM: begin
                    r_bg  <= r_node_rd.g;
                    r_sum <= sum_full[CNT_W-1:0];
                    r_s   <= '0;
                end
                OP_SCHK:  r_s <= r_s + SYM_W'(1);
                OP_HEAD2: begin
                    r_head <= r_head + IDX_W'(2);
                    r_k    <= r_head + IDX_W'(2);
                end
                OP_JRD:   if (r_k >= r_tail) r_head <= r_head - IDX_W'(1);
                OP_JCMP: begin
                    if (r_node_rd.w < r_sum) r_k <= r_k + IDX_W'(1);
                    else                     r_head <= r_head - IDX_W'(1);
                end
                OP_ELD: begin
                    r_rem  <= (r_len_rd > LEN_W'(MAX_LEN)) ? '0 : r_len_rd;
                    r_code <= r_bits_rd;
                end
                default: ;
            endcase

            if (step_go) begin
                r_rem <= rem_after;
                if (fills) begin
                    r_buf  <= '0;
                    r_fill <= '0;
                end else begin
                    r_buf  <= nb;
                    r_fill <= new_fill[2:0];
                end
            end else if (emit_byte) begin
                r_buf  <= '0;
                r_fill <= '0;
            end

            // output register
            if (emit_byte) begin
                r_ov    <= 1'b1;
                r_ob    <= (i_cmd.op == OP_FOUT) ? r_buf : nb;
                r_ois   <= 1'b0;
                r_ost   <= BS_OK;
                r_olast <= (i_cmd.op == OP_FOUT) || (rem_after < LEN_W'(8));
            end else if ((i_cmd.op == OP_EMIT) && out_free) begin
                r_ov    <= 1'b1;
                r_ob    <= '0;
                r_ois   <= 1'b1;
                r_ost   <= i_cmd.st;
                r_olast <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.out_free  = out_free;
        o_stat.cnt_nz    = (r_cnt_rd != '0);
        o_stat.k_zero    = (r_k == '0);
        o_stat.node_ge   = (r_node_rd.w >= r_w);
        o_stat.s_last    = (r_s == SYM_W'(SYMBOLS - 1));
        o_stat.n_zero    = (n_live == '0);
        o_stat.n_one     = (n_live == IDX_W'(1));
        o_stat.n_gt1     = (n_live > IDX_W'(1));
        o_stat.ovf       = sum_full[CNT_W];
        o_stat.len_err   = len_err;
        o_stat.k_lt_tail = (r_k < r_tail);
        o_stat.node_lt   = (r_node_rd.w < r_sum);
        o_stat.rem_zero  = (r_rem == '0);
        o_stat.fill_zero = (r_fill == '0);
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_is_status = r_ois;
    assign o_status    = r_ost;
    assign o_last      = r_olast;

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("node list head passed tail");
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= IDX_W'(SYMBOLS)) else $error("node list overrun");
    a_byte_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_byte |=> (r_fill == '0) && (r_buf == '0))
        else $error("bit buffer not cleared after byte");
    a_status_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ois) |-> (r_ob == '0) && r_olast)
        else $error("status item carries byte");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= LEN_W'(MAX_LEN)) else $error("code length out of range");

endmodule

// ===== src/huffman_code_build_and_encode_unit.sv =====
// load item: taken while idle, no result, no stall; flush: emits any partial byte;
// encode: reads the code, then packs it into the byte buffer, touching up to 7 bytes
// build: scans every symbol, inserts each leaf into the sorted node list by shifting,
// then per merge a sweep of all 256 symbols plus the sorted-node insertion walk
// one item at a time; input stalls until the item's last result is registered
// reset (synchronous, active low) clears counts and code lengths via valid flags
module huffman_code_build_and_encode_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_kind,
    input  logic [hcb_pkg::SYM_W-1:0] i_symbol,
    input  logic [hcb_pkg::CNT_W-1:0] i_count,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_is_status,
    output logic [1:0]                o_status,
    output logic                      o_last
);
    import hcb_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_kind    kind;
    logic     accept;

    // item enters only while the controller sits idle
    assign kind   = t_kind'(i_kind);
    assign accept = i_in_valid && !o_in_stall;

    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (kind),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // memories, node list walk, bit packer and output register
    hcb_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_accept    (accept),
        .i_kind      (kind),
        .i_symbol    (i_symbol),
        .i_count     (i_count),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_is_status (o_is_status),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

// ===== bench/tb_huffman_code_build_and_encode_unit.sv =====
module tb_huffman_code_build_and_encode_unit;
    import hcb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int TARGET_ITEMS = 230;
    localparam int DRAIN_CYCLES = 64;

    // one expected result of the block
    typedef struct {
        logic [7:0] out_byte;
        logic       is_status;
        t_bstat     status;
        logic       last;
    } huff_result_t;

    // code table model and the queue of results it predicts
    class huff_scoreboard;
        logic [CNT_W-1:0]  sym_count [SYMBOLS];
        logic [CODE_W-1:0] code_word [SYMBOLS];
        int unsigned       code_len [SYMBOLS];
        int unsigned       sym_group [SYMBOLS];
        longint unsigned   node_weight [SYMBOLS];
        int unsigned       node_group [SYMBOLS];
        int unsigned       node_cnt;
        logic [7:0]        pack_reg;
        int unsigned       pack_fill;
        huff_result_t      pending[$];
        int                errors;
        int                bytes_seen;
        int                status_seen;

        function new();
            for (int s = 0; s < SYMBOLS; s++) begin
                sym_count[s] = '0;
                code_word[s] = '0;
                code_len[s]  = 0;
                sym_group[s] = 0;
            end
            node_cnt    = 0;
            pack_reg    = '0;
            pack_fill   = 0;
            errors      = 0;
            bytes_seen  = 0;
            status_seen = 0;
        endfunction

        function void wipe_codes();
            for (int s = 0; s < SYMBOLS; s++) begin
                code_word[s] = '0;
                code_len[s]  = 0;
            end
        endfunction

        // sorted insert, new node goes ahead of equal weights
        function void place_node(longint unsigned w, int unsigned g);
            int unsigned pos;
            pos = 0;
            if (node_cnt >= SYMBOLS) return;
            while (pos < node_cnt && node_weight[pos] < w) pos++;
            for (int unsigned i = node_cnt; i > pos; i--) begin
                node_weight[i] = node_weight[i-1];
                node_group[i]  = node_group[i-1];
            end
            node_weight[pos] = w;
            node_group[pos]  = g;
            node_cnt++;
        endfunction

        function t_bstat build_codes();
            longint unsigned wa, wb, total;
            int unsigned ga, gb;
            wipe_codes();
            node_cnt = 0;
            for (int s = 0; s < SYMBOLS; s++) begin
                if (sym_count[s] != 0) begin
                    sym_group[s] = s;
                    place_node(sym_count[s], s);
                end
            end
            if (node_cnt == 0) return BS_EMPTY;
            if (node_cnt == 1) begin
                code_word[node_group[0]] = CODE_W'(1);
                code_len[node_group[0]]  = 1;
                return BS_OK;
            end
            while (node_cnt > 1) begin
                wa = node_weight[0]; ga = node_group[0];
                wb = node_weight[1]; gb = node_group[1];
                total = wa + wb;
                if (total > ((64'd1 << CNT_W) - 1)) begin
                    wipe_codes();
                    node_cnt = 0;
                    return BS_OVF;
                end
                for (int s = 0; s < SYMBOLS; s++) begin
                    if (sym_count[s] == 0) continue;
                    if (sym_group[s] != ga && sym_group[s] != gb) continue;
                    if (code_len[s] >= MAX_LEN) begin
                        wipe_codes();
                        node_cnt = 0;
                        return BS_OVF;
                    end
                    if (sym_group[s] == gb) begin
                        code_word[s][code_len[s]] = 1'b1;
                        sym_group[s] = ga;
                    end
                    code_len[s]++;
                end
                for (int unsigned i = 2; i < node_cnt; i++) begin
                    node_weight[i-2] = node_weight[i];
                    node_group[i-2]  = node_group[i];
                end
                node_cnt -= 2;
                place_node(total, ga);
            end
            return BS_OK;
        endfunction

        function void push_result(logic [7:0] b, logic st_f, t_bstat st, logic lst);
            huff_result_t r;
            r.out_byte = b; r.is_status = st_f; r.status = st; r.last = lst;
            pending.push_back(r);
        endfunction

        // called once per accepted input item
        function void note_item(t_kind k, logic [7:0] s, logic [CNT_W-1:0] c);
            int made;
            made = 0;
            case (k)
                K_LOAD: sym_count[s] = c;
                K_BUILD: push_result(8'h00, 1'b1, build_codes(), 1'b1);
                K_ENC: begin
                    for (int i = code_len[s]; i > 0; i--) begin
                        pack_reg[pack_fill] = code_word[s][i-1];
                        pack_fill++;
                        if (pack_fill == 8) begin
                            push_result(pack_reg, 1'b0, BS_OK, 1'b0);
                            made++;
                            pack_reg  = '0;
                            pack_fill = 0;
                        end
                    end
                    if (made > 0) pending[$].last = 1'b1;
                end
                default: begin
                    if (pack_fill > 0) begin
                        push_result(pack_reg, 1'b0, BS_OK, 1'b1);
                        pack_reg  = '0;
                        pack_fill = 0;
                    end
                end
            endcase
        endfunction

        // called once per accepted result
        function void check_result(logic [7:0] b, logic st_f, logic [1:0] st, logic lst);
            huff_result_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result byte %h is_status %b status %0d last %b",
                         $time, b, st_f, st, lst);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st_f) status_seen++; else bytes_seen++;
            if (b !== e.out_byte) begin
                $display("%0t out_byte exp %h act %h", $time, e.out_byte, b);
                errors++;
            end
            if (st_f !== e.is_status) begin
                $display("%0t is_status exp %b act %b", $time, e.is_status, st_f);
                errors++;
            end
            if (st !== e.status) begin
                $display("%0t status exp %0d act %0d", $time, e.status, st);
                errors++;
            end
            if (lst !== e.last) begin
                $display("%0t last exp %b act %b", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [1:0]       i_kind = K_LOAD;
    logic [SYM_W-1:0] i_symbol = '0;
    logic [CNT_W-1:0] i_count = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [7:0]       o_out_byte;
    logic             o_is_status;
    logic [1:0]       o_status;
    logic             o_last;

    huffman_code_build_and_encode_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_symbol    (i_symbol),
        .i_count     (i_count),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_is_status (o_is_status),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always #2 i_clk = ~i_clk;

    huff_scoreboard sb = new();

    // idle rates in percent for sender and receiver
    int send_idle = 38;
    int recv_idle = 75;
    int items_sent = 0;
    int builds_sent = 0;
    int cycle_no = 0;
    // symbols that may hold a nonzero count
    logic [SYM_W-1:0] loaded_syms[$];

    // global watchdog
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("tb_huffman_code_build_and_encode_unit: errors");
            $finish;
        end
    end

    // result side: check on accept, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_byte, o_is_status, o_status, o_last);
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    // present one item, holding it until the block takes it
    task automatic send_item(t_kind k, logic [SYM_W-1:0] s, logic [CNT_W-1:0] c);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            i_kind     <= 2'($urandom);
            i_symbol   <= SYM_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= k;
        i_symbol   <= s;
        i_count    <= c;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(k, s, c);
        items_sent++;
        if (k == K_BUILD) builds_sent++;
        if (k == K_LOAD && c != 0) loaded_syms.push_back(s);
    endtask

    // drop every count to zero so the next set stands alone
    task automatic clear_counts();
        logic [SYM_W-1:0] s;
        while (loaded_syms.size() > 0) begin
            s = loaded_syms.pop_front();
            if (sb.sym_count[s] != 0) send_item(K_LOAD, s, '0);
        end
    endtask

    // well-formed sequence: fresh counts, build, stream of encodes with occasional flushes, flush
    task automatic code_session(int n_syms, int shape);
        logic [SYM_W-1:0] pick[$];
        logic [SYM_W-1:0] perm[SYMBOLS];
        logic [SYM_W-1:0] t;
        logic [CNT_W-1:0] c;
        longint unsigned fa, fb, fc;
        int j, n_enc;
        for (int i = 0; i < SYMBOLS; i++) perm[i] = SYM_W'(i);
        for (int i = SYMBOLS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        clear_counts();
        fa = 1; fb = 1;
        for (int i = 0; i < n_syms; i++) begin
            pick.push_back(perm[i]);
            case (shape)
                // fibonacci weights give one long chain of codes
                1: begin
                    c = CNT_W'(fa);
                    fc = fa + fb; fa = fb; fb = fc;
                end
                // heavy weights that may overflow the merged sum
                2: c = CNT_W'($urandom_range(32'h7FFF_FFFF, 32'h2000_0000));
                // plenty of ties
                3: c = CNT_W'($urandom_range(3, 1));
                default: c = CNT_W'($urandom_range(1000, 1));
            endcase
            send_item(K_LOAD, perm[i], c);
        end
        send_item(K_BUILD, SYM_W'($urandom), CNT_W'($urandom));
        n_enc = $urandom_range(20, 6);
        for (int i = 0; i < n_enc; i++) begin
            if ($urandom_range(19) == 0)
                send_item(K_FLUSH, SYM_W'($urandom), '0);
            else
                send_item(K_ENC, pick[$urandom_range(n_syms - 1)], CNT_W'($urandom));
        end
        send_item(K_FLUSH, SYM_W'($urandom), '0);
    endtask

    initial begin
        int r;
        bit did_deep, did_wide;
        did_deep = 0;
        did_wide = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, lone symbol, flush on empty, encode without code
        send_item(K_BUILD, 8'h00, '0);
        send_item(K_ENC, 8'h00, '0);
        send_item(K_FLUSH, 8'h00, '0);
        send_item(K_LOAD, 8'hFF, {CNT_W{1'b1}});
        send_item(K_BUILD, 8'h00, '0);
        send_item(K_ENC, 8'hFF, '0);
        send_item(K_ENC, 8'h00, '0);
        send_item(K_FLUSH, 8'h00, '0);
        send_item(K_FLUSH, 8'hFF, '0);
        // two full-scale counts overflow the merged weight
        send_item(K_LOAD, 8'h00, {CNT_W{1'b1}});
        send_item(K_BUILD, 8'h00, '0);
        send_item(K_ENC, 8'h00, '0);
        // smallest counts, merge of two leaves, encode a run of bits
        send_item(K_LOAD, 8'hFF, CNT_W'(1));
        send_item(K_LOAD, 8'h00, CNT_W'(1));
        send_item(K_BUILD, 8'hFF, {CNT_W{1'b1}});
        for (int i = 0; i < 9; i++) send_item(K_ENC, (i % 2) ? 8'hFF : 8'h00, '0);
        send_item(K_FLUSH, 8'h00, '0);
        loaded_syms.push_back(8'h00);
        loaded_syms.push_back(8'hFF);

        // random part in three idling phases
        while (items_sent < TARGET_ITEMS) begin
            if (items_sent > 2 * TARGET_ITEMS / 3) begin
                send_idle = 0; recv_idle = 0;
            end else if (items_sent > TARGET_ITEMS / 3) begin
                send_idle = 75; recv_idle = 38;
            end
            r = $urandom_range(99);
            if (!did_deep && items_sent > TARGET_ITEMS / 4) begin
                did_deep = 1;
                code_session(40, 1);
            end else if (!did_wide && items_sent > TARGET_ITEMS / 2) begin
                did_wide = 1;
                code_session(60, 0);
            end else if (r < 55) begin
                code_session($urandom_range(10, 2), 0);
            end else if (r < 65) begin
                code_session($urandom_range(6, 2), 3);
            end else if (r < 72) begin
                code_session($urandom_range(4, 2), 2);
            end else begin
                // noise: any kind, any symbol, any count
                send_item(t_kind'($urandom_range(3)), SYM_W'($urandom), CNT_W'($urandom));
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items with %0d builds, checked %0d bytes and %0d status results",
                 items_sent, builds_sent, sb.bytes_seen, sb.status_seen);
        if (sb.errors == 0)
            $display("tb_huffman_code_build_and_encode_unit: clean");
        else
            $display("tb_huffman_code_build_and_encode_unit: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hcb_pkg.sv
src/hcb_ctrl.sv
src/hcb_dpath.sv
src/huffman_code_build_and_encode_unit.sv
bench/tb_huffman_code_build_and_encode_unit.sv
